/* hdl/mvp_pkg.sv */
// Package for the matrix vector product block: payload structs, internal
// control structs, codes and size constants. Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package mvp_pkg;

  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;
  localparam int ELEM_W       = 16;
  localparam int PROD_W       = 2 * ELEM_W;
  localparam int DOT_W        = 36;
  localparam int CNT_W        = 5;
  localparam int ROW_IDX_W    = 4;
  localparam int TOTAL_W      = 2 * CNT_W;
  localparam int CFG_RESET    = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic KIND_MATRIX = 1'b0;
  localparam logic KIND_VECTOR = 1'b1;

  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic signed [ELEM_W-1:0] element_value;
    logic                     last;
  } mvp_in_t;

  typedef struct packed {
    logic [ROW_IDX_W-1:0]    row_index;
    logic signed [DOT_W-1:0] dot_value;
    logic                    last_row;
    logic                    size_error;
  } mvp_out_t;

  typedef struct packed {
    logic size_error;
  } mvp_job_t;

  typedef struct packed {
    logic [CNT_W-1:0] row_count;
    logic [CNT_W-1:0] col_count;
  } mvp_cfg_t;

  typedef struct packed {
    logic                     mat_we;
    logic                     vec_we;
    logic signed [ELEM_W-1:0] data;
  } mvp_wr_t;

  typedef struct packed {
    logic prod_done;
  } mvp_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_DRAIN
  } mvp_bk_state_t;

endpackage
`default_nettype wire

/* hdl/mvp_front.sv */
// Front end: holds the configuration registers, accepts input transactions,
// steers element writes and queues product or error jobs. Uses mvp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mvp_front #(
  parameter int MAX_ROWS = mvp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mvp_pkg::MAX_COLS_DEF,
  localparam int ADDR_W = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1,
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire mvp_pkg::mvp_in_t           in_data,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [mvp_pkg::CNT_W-1:0]  cfg_data,
  output mvp_pkg::mvp_cfg_t               cfg,
  output mvp_pkg::mvp_wr_t                wr,
  output logic [ADDR_W-1:0]               wr_mat_addr,
  output logic [COL_W-1:0]                wr_vec_addr,
  output logic                            q_push,
  output mvp_pkg::mvp_job_t               q_job,
  input  wire logic                       q_full,
  input  wire mvp_pkg::mvp_stat_t         stat
);

  localparam int VCNT_W = $clog2(MAX_COLS + 2);
  localparam int CMP_W  = (ADDR_W + 1 > mvp_pkg::TOTAL_W) ? ADDR_W + 1 : mvp_pkg::TOTAL_W;
  localparam int LEN_W  = (VCNT_W > mvp_pkg::CNT_W) ? VCNT_W : mvp_pkg::CNT_W;
  localparam logic [mvp_pkg::CNT_W-1:0] ROWS_RST =
    mvp_pkg::CNT_W'((mvp_pkg::CFG_RESET > MAX_ROWS) ? MAX_ROWS : mvp_pkg::CFG_RESET);
  localparam logic [mvp_pkg::CNT_W-1:0] COLS_RST =
    mvp_pkg::CNT_W'((mvp_pkg::CFG_RESET > MAX_COLS) ? MAX_COLS : mvp_pkg::CFG_RESET);
  localparam logic [VCNT_W-1:0] VCNT_MAX = VCNT_W'(MAX_COLS);

  function automatic logic [mvp_pkg::CNT_W-1:0] clamp_cnt(
    input logic [mvp_pkg::CNT_W-1:0] v,
    input int                        hi
  );
    logic [mvp_pkg::CNT_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = mvp_pkg::CNT_W'(1);
    end else if (int'(v) > hi) begin
      res = mvp_pkg::CNT_W'(hi);
    end
    return res;
  endfunction

  mvp_pkg::mvp_cfg_t      cfg_r, cfg_nxt;
  logic [ADDR_W-1:0]      ptr_r, ptr_nxt;
  logic [VCNT_W-1:0]      vcnt_r, vcnt_nxt;
  logic                   busy_r, busy_nxt;
  logic [mvp_pkg::TOTAL_W-1:0] total;
  logic [CMP_W-1:0]       ptr_inc;
  logic [VCNT_W-1:0]      vcnt_inc;
  logic                   in_acc;

  assign total    = mvp_pkg::TOTAL_W'(cfg_r.row_count) * mvp_pkg::TOTAL_W'(cfg_r.col_count);
  assign ptr_inc  = CMP_W'(ptr_r) + CMP_W'(1);
  assign vcnt_inc = (vcnt_r <= VCNT_MAX) ? vcnt_r + VCNT_W'(1) : vcnt_r;
  assign in_ready = !q_full && !busy_r;
  assign in_acc   = in_valid && in_ready;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt     = cfg_r;
    ptr_nxt     = ptr_r;
    vcnt_nxt    = vcnt_r;
    busy_nxt    = busy_r;
    wr.mat_we   = 1'b0;
    wr.vec_we   = 1'b0;
    wr.data     = in_data.element_value;
    wr_mat_addr = ptr_r;
    wr_vec_addr = vcnt_r[COL_W-1:0];
    q_push      = 1'b0;
    q_job.size_error = (LEN_W'(vcnt_inc) != LEN_W'(cfg_r.col_count));
    if (stat.prod_done) begin
      busy_nxt = 1'b0;
    end
    if (cfg_we) begin
      case (cfg_index)
        mvp_pkg::CFG_ROW_COUNT: cfg_nxt.row_count = clamp_cnt(cfg_data, MAX_ROWS);
        mvp_pkg::CFG_COL_COUNT: cfg_nxt.col_count = clamp_cnt(cfg_data, MAX_COLS);
        default: cfg_nxt = cfg_r;
      endcase
      ptr_nxt  = '0;
      vcnt_nxt = '0;
    end else if (in_acc) begin
      case (in_data.kind)
        mvp_pkg::KIND_MATRIX: begin
          wr.mat_we = 1'b1;
          ptr_nxt   = (ptr_inc >= CMP_W'(total)) ? '0 : ADDR_W'(ptr_inc);
        end
        mvp_pkg::KIND_VECTOR: begin
          wr.vec_we = (vcnt_r < VCNT_MAX);
          vcnt_nxt  = vcnt_inc;
          if (in_data.last) begin
            vcnt_nxt = '0;
            q_push   = 1'b1;
            if (!q_job.size_error) begin
              busy_nxt = 1'b1;
            end
          end
        end
        default: ptr_nxt = ptr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_count <= ROWS_RST;
      cfg_r.col_count <= COLS_RST;
      ptr_r           <= '0;
      vcnt_r          <= '0;
      busy_r          <= 1'b0;
    end else begin
      cfg_r  <= cfg_nxt;
      ptr_r  <= ptr_nxt;
      vcnt_r <= vcnt_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/mvp_queue.sv */
// Short job queue between the front end and the product engine.
// Uses mvp_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none
module mvp_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire mvp_pkg::mvp_job_t push_job,
  output logic                   full,
  input  wire logic              pop,
  output mvp_pkg::mvp_job_t      pop_job,
  output logic                   valid
);

  localparam int DEPTH = mvp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mvp_pkg::mvp_job_t  slot_r [DEPTH];
  logic [PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [PTR_W-1:0]   rptr_r, rptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_job = slot_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/mvp_back.sv */
// Product engine: matrix and vector memories, a row and column sequencer,
// a registered multiply and accumulate pipeline and the result register.
// Uses mvp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mvp_back #(
  parameter int MAX_ROWS = mvp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mvp_pkg::MAX_COLS_DEF,
  localparam int ADDR_W = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1,
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mvp_pkg::mvp_cfg_t   cfg,
  input  wire mvp_pkg::mvp_wr_t    wr,
  input  wire logic [ADDR_W-1:0]   wr_mat_addr,
  input  wire logic [COL_W-1:0]    wr_vec_addr,
  input  wire logic                q_valid,
  input  wire mvp_pkg::mvp_job_t   q_job,
  output logic                     q_pop,
  output mvp_pkg::mvp_stat_t       stat,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mvp_pkg::mvp_out_t        out_data
);

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RCMP_W = ((ROW_W > mvp_pkg::CNT_W) ? ROW_W : mvp_pkg::CNT_W) + 1;
  localparam int CCMP_W = ((COL_W > mvp_pkg::CNT_W) ? COL_W : mvp_pkg::CNT_W) + 1;

  logic signed [mvp_pkg::ELEM_W-1:0] mat_mem [MAX_ROWS * MAX_COLS];
  logic signed [mvp_pkg::ELEM_W-1:0] vec_mem [MAX_COLS];

  mvp_pkg::mvp_bk_state_t            state_r, state_nxt;
  logic [ROW_W-1:0]                  row_r, row_nxt;
  logic [COL_W-1:0]                  col_r, col_nxt;
  logic [ADDR_W-1:0]                 addr_r, addr_nxt;
  logic                              s1_v_r, s2_v_r;
  logic signed [mvp_pkg::ELEM_W-1:0] mat_q_r, vec_q_r;
  logic signed [mvp_pkg::PROD_W-1:0] prod_r;
  logic signed [mvp_pkg::DOT_W-1:0]  acc_r, acc_nxt;
  logic                              out_valid_r, out_valid_nxt;
  mvp_pkg::mvp_out_t                 out_data_r, out_data_nxt;
  logic                              issue;
  logic                              col_last;
  logic                              row_last;

  assign col_last  = (CCMP_W'(col_r) + CCMP_W'(1)) == CCMP_W'(cfg.col_count);
  assign row_last  = (RCMP_W'(row_r) + RCMP_W'(1)) == RCMP_W'(cfg.row_count);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    addr_nxt       = addr_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    acc_nxt        = s2_v_r ? acc_r + mvp_pkg::DOT_W'(prod_r) : acc_r;
    issue          = 1'b0;
    q_pop          = 1'b0;
    stat.prod_done = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      mvp_pkg::BK_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_pop = 1'b1;
          if (q_job.size_error) begin
            out_data_nxt.row_index  = '0;
            out_data_nxt.dot_value  = '0;
            out_data_nxt.last_row   = 1'b1;
            out_data_nxt.size_error = 1'b1;
            out_valid_nxt           = 1'b1;
          end else begin
            state_nxt = mvp_pkg::BK_ISSUE;
            row_nxt   = '0;
            col_nxt   = '0;
            addr_nxt  = '0;
            acc_nxt   = '0;
          end
        end
      end
      mvp_pkg::BK_ISSUE: begin
        issue    = 1'b1;
        col_nxt  = col_r + COL_W'(1);
        addr_nxt = addr_r + ADDR_W'(1);
        if (col_last) begin
          col_nxt   = '0;
          state_nxt = mvp_pkg::BK_DRAIN;
        end
      end
      mvp_pkg::BK_DRAIN: begin
        if (!s1_v_r && !s2_v_r && !out_valid_r) begin
          out_data_nxt.row_index  = mvp_pkg::ROW_IDX_W'(row_r);
          out_data_nxt.dot_value  = acc_r;
          out_data_nxt.last_row   = row_last;
          out_data_nxt.size_error = 1'b0;
          out_valid_nxt           = 1'b1;
          acc_nxt                 = '0;
          if (row_last) begin
            state_nxt      = mvp_pkg::BK_IDLE;
            stat.prod_done = 1'b1;
          end else begin
            row_nxt   = row_r + ROW_W'(1);
            state_nxt = mvp_pkg::BK_ISSUE;
          end
        end
      end
      default: state_nxt = mvp_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.mat_we) begin
      mat_mem[wr_mat_addr] <= wr.data;
    end
    if (issue) begin
      mat_q_r <= mat_mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.vec_we) begin
      vec_mem[wr_vec_addr] <= wr.data;
    end
    if (issue) begin
      vec_q_r <= vec_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      prod_r <= mat_q_r * vec_q_r;
    end
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    addr_r     <= addr_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mvp_pkg::BK_IDLE;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_v_r      <= issue;
      s2_v_r      <= s1_v_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_done_emits_last: assert property (@(posedge clk) disable iff (!rst_n)
    stat.prod_done |=> out_valid_r && out_data_r.last_row && !out_data_r.size_error)
    else $error("product run ended without a final row result");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mvp_pkg::BK_IDLE) |-> !s1_v_r && !s2_v_r)
    else $error("multiply pipeline busy while the engine is idle");

  a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.size_error |->
      out_data_r.last_row && (out_data_r.dot_value == '0) && (out_data_r.row_index == '0))
    else $error("malformed size error result");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job popped from an empty queue");

endmodule
`default_nettype wire

/* hdl/matrix_vector_product_top.sv */
// Matrix vector product, top level. Element loads: one transaction a cycle while
// in_ready is high. Each row of a product passes the memory read, multiply and
// accumulate registers into the result register, held back while the previous
// result still waits there. A size error gives its single result once its job
// leaves the job queue. Input stalls during a run.
// Reset is synchronous and clears control state; the stores stay undefined.
`timescale 1ns / 1ps
`default_nettype none
module matrix_vector_product_top #(
  parameter int MAX_ROWS = mvp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mvp_pkg::MAX_COLS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire mvp_pkg::mvp_in_t          in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output mvp_pkg::mvp_out_t              out_data,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [mvp_pkg::CNT_W-1:0] cfg_data
);

  localparam int ADDR_W = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  mvp_pkg::mvp_cfg_t  cfg;
  mvp_pkg::mvp_wr_t   wr;
  logic [ADDR_W-1:0]  wr_mat_addr;
  logic [COL_W-1:0]   wr_vec_addr;
  logic               q_push;
  mvp_pkg::mvp_job_t  q_push_job;
  logic               q_full;
  logic               q_pop;
  mvp_pkg::mvp_job_t  q_pop_job;
  logic               q_valid;
  mvp_pkg::mvp_stat_t stat;

  mvp_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cfg         (cfg),
    .wr          (wr),
    .wr_mat_addr (wr_mat_addr),
    .wr_vec_addr (wr_vec_addr),
    .q_push      (q_push),
    .q_job       (q_push_job),
    .q_full      (q_full),
    .stat        (stat)
  );

  mvp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_pop_job),
    .valid    (q_valid)
  );

  mvp_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .wr          (wr),
    .wr_mat_addr (wr_mat_addr),
    .wr_vec_addr (wr_vec_addr),
    .q_valid     (q_valid),
    .q_job       (q_pop_job),
    .q_pop       (q_pop),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire
